FILE: hdl/qrp_pkg.sv
`default_nettype none

package qrp_pkg;

  localparam int COORD_W = 32;
  localparam int Q_FRAC  = 30;

  // first product: three 64-bit terms, rounded to Q6.30 (30 fraction bits) with full integer range
  localparam int PROD1_W = 2 * COORD_W;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int T_W     = SUM1_W - Q_FRAC;

  // second product: t is cut at bit SPLIT into a signed high and unsigned low part
  localparam int SPLIT   = 16;
  localparam int THI_W   = T_W - SPLIT;
  localparam int PHI_W   = THI_W + COORD_W;
  localparam int PLO_W   = SPLIT + 1 + COORD_W;
  localparam int PROD2_W = T_W + COORD_W;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int R_W     = SUM2_W - Q_FRAC;

  localparam int N_PROD2 = 12;

  localparam logic signed [SUM1_W-1:0] ROUND1 = SUM1_W'(1) << (Q_FRAC - 1);
  localparam logic signed [SUM2_W-1:0] ROUND2 = SUM2_W'(1) << (Q_FRAC - 1);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic signed [COORD_W-1:0] QUAT_X_RESET = COORD_W'(1) << Q_FRAC;

  localparam int ADDR_W = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
    logic signed [T_W-1:0] w;
  } tvec_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

`default_nettype wire

FILE: hdl/qrp_cfg.sv
`default_nettype none

module qrp_cfg
  import qrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output quat_t                  quat
);

  reg_index_t idx;
  logic       wr;

  assign idx    = reg_index_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= QUAT_X_RESET;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_QUAT_X: quat.x <= pwdata;
        REG_QUAT_Y: quat.y <= pwdata;
        REG_QUAT_Z: quat.z <= pwdata;
        REG_QUAT_W: quat.w <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QUAT_X: prdata = quat.x;
      REG_QUAT_Y: prdata = quat.y;
      REG_QUAT_Z: prdata = quat.z;
      REG_QUAT_W: prdata = quat.w;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/qrp_mul1.sv
`default_nettype none

// t = q * (a, b, c, 0): products registered, then summed and rounded to Q6.30
module qrp_mul1
  import qrp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire coord_t a,
  input  wire coord_t b,
  input  wire coord_t c,
  input  wire quat_t  quat,
  output logic        t_valid,
  output tvec_t       t
);

  logic signed [PROD1_W-1:0] pwa, pyc, pzb, pwb, pza, pxc, pwc, pxb, pya, pxa, pyb, pzc;
  logic                      pv;
  logic signed [SUM1_W-1:0]  s_x, s_y, s_z, s_w;

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else     pv <= in_valid;
  end

  always_ff @(posedge clk) begin
    pwa <= quat.w * a;
    pyc <= quat.y * c;
    pzb <= quat.z * b;
    pwb <= quat.w * b;
    pza <= quat.z * a;
    pxc <= quat.x * c;
    pwc <= quat.w * c;
    pxb <= quat.x * b;
    pya <= quat.y * a;
    pxa <= quat.x * a;
    pyb <= quat.y * b;
    pzc <= quat.z * c;
  end

  assign s_x = SUM1_W'(pwa) + SUM1_W'(pyc) - SUM1_W'(pzb) + ROUND1;
  assign s_y = SUM1_W'(pwb) + SUM1_W'(pza) - SUM1_W'(pxc) + ROUND1;
  assign s_z = SUM1_W'(pwc) + SUM1_W'(pxb) - SUM1_W'(pya) + ROUND1;
  assign s_w = ROUND1 - SUM1_W'(pxa) - SUM1_W'(pyb) - SUM1_W'(pzc);

  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else     t_valid <= pv;
  end

  always_ff @(posedge clk) begin
    t.x <= s_x[SUM1_W-1:Q_FRAC];
    t.y <= s_y[SUM1_W-1:Q_FRAC];
    t.z <= s_z[SUM1_W-1:Q_FRAC];
    t.w <= s_w[SUM1_W-1:Q_FRAC];
  end

endmodule

`default_nettype wire

FILE: hdl/qrp_mul2.sv
`default_nettype none

// r = t * conj(q), vector part. Each 36x32 product is taken as two partial
// products, joined in the next stage, then the four terms per axis are summed.
module qrp_mul2
  import qrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire tvec_t t,
  input  wire quat_t quat,
  output logic       r_valid,
  output rvec_t      r
);

  logic signed [T_W-1:0]     op_t [N_PROD2];
  logic signed [COORD_W-1:0] op_q [N_PROD2];
  logic signed [PHI_W-1:0]   phi  [N_PROD2];
  logic signed [PLO_W-1:0]   plo  [N_PROD2];
  logic signed [PROD2_W-1:0] prod [N_PROD2];
  logic                      vc, vd;
  logic signed [SUM2_W-1:0]  s_x, s_y, s_z;

  // term order per axis: +w*t_axis, -tw*q_axis, -t_next*q_prev, +t_prev*q_next
  always_comb begin
    op_t[0]  = t.x; op_q[0]  = quat.w;
    op_t[1]  = t.w; op_q[1]  = quat.x;
    op_t[2]  = t.y; op_q[2]  = quat.z;
    op_t[3]  = t.z; op_q[3]  = quat.y;
    op_t[4]  = t.y; op_q[4]  = quat.w;
    op_t[5]  = t.w; op_q[5]  = quat.y;
    op_t[6]  = t.z; op_q[6]  = quat.x;
    op_t[7]  = t.x; op_q[7]  = quat.z;
    op_t[8]  = t.z; op_q[8]  = quat.w;
    op_t[9]  = t.w; op_q[9]  = quat.z;
    op_t[10] = t.x; op_q[10] = quat.y;
    op_t[11] = t.y; op_q[11] = quat.x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc      <= 1'b0;
      vd      <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      vc      <= in_valid;
      vd      <= vc;
      r_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_PROD2; i++) begin
      phi[i]  <= $signed(op_t[i][T_W-1:SPLIT]) * op_q[i];
      plo[i]  <= $signed({1'b0, op_t[i][SPLIT-1:0]}) * op_q[i];
      prod[i] <= (PROD2_W'(phi[i]) <<< SPLIT) + PROD2_W'(plo[i]);
    end
  end

  assign s_x = SUM2_W'(prod[0]) - SUM2_W'(prod[1]) - SUM2_W'(prod[2])
             + SUM2_W'(prod[3]) + ROUND2;
  assign s_y = SUM2_W'(prod[4]) - SUM2_W'(prod[5]) - SUM2_W'(prod[6])
             + SUM2_W'(prod[7]) + ROUND2;
  assign s_z = SUM2_W'(prod[8]) - SUM2_W'(prod[9]) - SUM2_W'(prod[10])
             + SUM2_W'(prod[11]) + ROUND2;

  always_ff @(posedge clk) begin
    r.x <= s_x[SUM2_W-1:Q_FRAC];
    r.y <= s_y[SUM2_W-1:Q_FRAC];
    r.z <= s_z[SUM2_W-1:Q_FRAC];
  end

`ifndef SYNTH
  a_valid_latency: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> $past(in_valid, 3))
    else $error("second product valid without an item three cycles back");
`endif

endmodule

`default_nettype wire

FILE: hdl/quaternion_rotate_point.sv
`default_nettype none

// channel   signals                               handshake
// config    psel penable pwrite paddr pwdata      write at psel&penable&pwrite, pready high
//           prdata pready
// input     point_x point_y point_z               accepted when start && !busy
// result    rot_x rot_y rot_z saturated           valid for one cycle while done is high
//
// One item per cycle; busy stays low, so start is taken on every cycle.
// From accept to done an item passes these registered stages: products of q*p, rounded sum,
// split partial products of t*conj(q), joined products, rounded sum, clip.
// The multiplier stages set the rate; there is no feedback between items.
// Reset clears the valid bits and loads the quaternion with a half turn about x.
module quaternion_rotate_point
  import qrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire coord_t            point_x,
  input  wire coord_t            point_y,
  input  wire coord_t            point_z,
  output logic                   done,
  output coord_t                 rot_x,
  output coord_t                 rot_y,
  output coord_t                 rot_z,
  output logic                   saturated
);

  quat_t quat;
  logic  accept;
  logic  t_valid;
  tvec_t t;
  logic  r_valid;
  rvec_t r;
  logic  sat_x, sat_y, sat_z;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  qrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat    (quat)
  );

  qrp_mul1 u_mul1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .a        (point_x),
    .b        (point_y),
    .c        (point_z),
    .quat     (quat),
    .t_valid  (t_valid),
    .t        (t)
  );

  qrp_mul2 u_mul2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t_valid),
    .t        (t),
    .quat     (quat),
    .r_valid  (r_valid),
    .r        (r)
  );

  // out of range when the bits above the sign do not all match it
  assign sat_x = (r.x[R_W-1:COORD_W-1] != {(R_W-COORD_W+1){r.x[R_W-1]}});
  assign sat_y = (r.y[R_W-1:COORD_W-1] != {(R_W-COORD_W+1){r.y[R_W-1]}});
  assign sat_z = (r.z[R_W-1:COORD_W-1] != {(R_W-COORD_W+1){r.z[R_W-1]}});

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= r_valid;
  end

  always_ff @(posedge clk) begin
    rot_x     <= sat_x ? (r.x[R_W-1] ? COORD_MIN : COORD_MAX) : r.x[COORD_W-1:0];
    rot_y     <= sat_y ? (r.y[R_W-1] ? COORD_MIN : COORD_MAX) : r.y[COORD_W-1:0];
    rot_z     <= sat_z ? (r.z[R_W-1] ? COORD_MIN : COORD_MAX) : r.z[COORD_W-1:0];
    saturated <= sat_x || sat_y || sat_z;
  end

`ifndef SYNTH
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result strobe without an item accepted six cycles earlier");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (rot_x == COORD_MAX || rot_x == COORD_MIN ||
                             rot_y == COORD_MAX || rot_y == COORD_MIN ||
                             rot_z == COORD_MAX || rot_z == COORD_MIN))
    else $error("saturated flag set but no coordinate at a bound");
`endif

endmodule

`default_nettype wire
